@@ src/bmfd_pkg.sv @@
// Shared constants and codes for the bar merge / fractal detect unit.
`timescale 1ns / 1ps
`default_nettype none

package bmfd_pkg;

  // Default storage widths for prices and bar positions.
  localparam int PRICE_WIDTH_DEF = 32;
  localparam int POS_WIDTH_DEF   = 16;

  // Port field widths.
  localparam int BAR_PRICE_W = 32;
  localparam int BAR_POS_W   = 16;
  localparam int PEAK_SEQ_W  = 16;

  // Window depth and fill counter width.
  localparam int WIN_DEPTH = 3;
  localparam int FILL_W    = 2;

  // Event codes on the result channel.
  typedef enum logic [1:0] {
    EV_BOTTOM = 2'd0,
    EV_TOP    = 2'd1,
    EV_ERROR  = 2'd2
  } event_kind_t;

endpackage

`default_nettype wire

@@ src/bar_merge_fractal_detect_unit.sv @@
// Bar merge and fractal detect unit: three-bar window, merge and peak detection.
`timescale 1ns / 1ps
`default_nettype none
// A result is registered and appears on out_* in the cycle after its bar transfer.
// Throughput: one bar per cycle while in_ready is high; the window update is one pass
//   of compares and muxes from the window registers back into them and into the result register.
// in_ready only drops while a result waits and out_ready is low.
// Reset (rst_n, synchronous, active low) clears fill count, phase, halt flag,
//   peak counter and result valid; no clearing pass is needed.

module bar_merge_fractal_detect_unit #(
  parameter int PRICE_WIDTH = bmfd_pkg::PRICE_WIDTH_DEF,
  parameter int POS_WIDTH   = bmfd_pkg::POS_WIDTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // bar input channel
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [bmfd_pkg::BAR_PRICE_W-1:0]  in_bar_high,
  input  wire  [bmfd_pkg::BAR_PRICE_W-1:0]  in_bar_low,
  input  wire  [bmfd_pkg::BAR_POS_W-1:0]    in_bar_pos,
  input  wire                               in_new_series,
  // peak result channel
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [1:0]                        out_event_kind,
  output logic [bmfd_pkg::BAR_POS_W-1:0]    out_peak_pos,
  output logic [bmfd_pkg::BAR_PRICE_W-1:0]  out_peak_price,
  output logic [bmfd_pkg::PEAK_SEQ_W-1:0]   out_peak_seq
);

  // Phase of the series: skip leading contained bars, merge until the window
  // is clean, then detect fractals.
  typedef enum logic [1:0] {
    PH_SKIP,
    PH_MERGE,
    PH_DETECT
  } phase_t;

  // Containment of bar b relative to bar a; equality counts as a inside b.
  typedef enum logic [1:0] {
    CT_NONE,
    CT_A_IN_B,
    CT_B_IN_A
  } cont_t;

  // Direction from bar a to bar b.
  typedef enum logic [1:0] {
    TR_FLAT,
    TR_UP,
    TR_DOWN
  } trend_t;

  typedef logic [PRICE_WIDTH-1:0] price_t;
  typedef logic [POS_WIDTH-1:0]   pos_t;

  function automatic cont_t contain_f(input price_t ah, input price_t al,
                                      input price_t bh, input price_t bl);
    cont_t res;
    if (ah <= bh && al >= bl) begin
      res = CT_A_IN_B;
    end else if (ah >= bh && al <= bl) begin
      res = CT_B_IN_A;
    end else begin
      res = CT_NONE;
    end
    return res;
  endfunction

  function automatic trend_t trend_f(input price_t ah, input price_t al,
                                     input price_t bh, input price_t bl);
    trend_t res;
    if (ah > bh && al > bl) begin
      res = TR_DOWN;
    end else if (ah < bh && al < bl) begin
      res = TR_UP;
    end else begin
      res = TR_FLAT;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // State: window slot 0 is the oldest bar.
  // ---------------------------------------------------------------------------
  price_t                           win_high_r [bmfd_pkg::WIN_DEPTH];
  price_t                           win_low_r  [bmfd_pkg::WIN_DEPTH];
  pos_t                             win_pos_r  [bmfd_pkg::WIN_DEPTH];
  logic [bmfd_pkg::FILL_W-1:0]      fill_count_r;
  phase_t                           phase_r;
  logic                             halted_r;
  logic [bmfd_pkg::PEAK_SEQ_W-1:0]  peak_counter_r;

  price_t                           win_high_nxt [bmfd_pkg::WIN_DEPTH];
  price_t                           win_low_nxt  [bmfd_pkg::WIN_DEPTH];
  pos_t                             win_pos_nxt  [bmfd_pkg::WIN_DEPTH];
  logic [bmfd_pkg::FILL_W-1:0]      fill_count_nxt;
  phase_t                           phase_nxt;
  logic                             halted_nxt;
  logic [bmfd_pkg::PEAK_SEQ_W-1:0]  peak_counter_nxt;

  // Result register (skid between the bar side and the result side).
  logic                             out_valid_r;
  bmfd_pkg::event_kind_t            out_kind_r;
  logic [bmfd_pkg::BAR_POS_W-1:0]   out_pos_r;
  logic [bmfd_pkg::BAR_PRICE_W-1:0] out_price_r;
  logic [bmfd_pkg::PEAK_SEQ_W-1:0]  out_seq_r;

  // Result of the current bar.
  logic                             res_valid;
  bmfd_pkg::event_kind_t            res_kind;
  logic [bmfd_pkg::BAR_POS_W-1:0]   res_pos;
  logic [bmfd_pkg::BAR_PRICE_W-1:0] res_price;
  logic [bmfd_pkg::PEAK_SEQ_W-1:0]  res_seq;

  // Incoming bar at storage width.
  price_t bar_h;
  price_t bar_l;
  pos_t   bar_p;

  // Working values of the step.
  logic   step_done;
  cont_t  cont_c;
  trend_t trend_d;

  logic   in_xfer;

  assign bar_h = PRICE_WIDTH'(in_bar_high);
  assign bar_l = PRICE_WIDTH'(in_bar_low);
  assign bar_p = POS_WIDTH'(in_bar_pos);

  // A new bar is taken whenever the result register is empty or drains now.
  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // One bar step: clear, fill, skip / merge / detect.
  // Phases cascade within one step since each exit test only looks at the
  // bars already in the window.
  // ---------------------------------------------------------------------------
  always_comb begin
    win_high_nxt     = win_high_r;
    win_low_nxt      = win_low_r;
    win_pos_nxt      = win_pos_r;
    fill_count_nxt   = fill_count_r;
    phase_nxt        = phase_r;
    halted_nxt       = halted_r;
    peak_counter_nxt = peak_counter_r;
    res_valid        = 1'b0;
    res_kind         = bmfd_pkg::EV_BOTTOM;
    res_pos          = '0;
    res_price        = '0;
    res_seq          = '0;
    step_done        = 1'b0;
    cont_c           = CT_NONE;
    trend_d          = TR_FLAT;

    if (in_new_series) begin
      for (int i = 0; i < bmfd_pkg::WIN_DEPTH; i++) begin
        win_high_nxt[i] = '0;
        win_low_nxt[i]  = '0;
        win_pos_nxt[i]  = '0;
      end
      fill_count_nxt   = '0;
      phase_nxt        = PH_SKIP;
      halted_nxt       = 1'b0;
      peak_counter_nxt = '0;
    end

    if (!halted_nxt) begin
      if (fill_count_nxt != bmfd_pkg::FILL_W'(bmfd_pkg::WIN_DEPTH)) begin
        // initial fill
        win_high_nxt[fill_count_nxt] = bar_h;
        win_low_nxt[fill_count_nxt]  = bar_l;
        win_pos_nxt[fill_count_nxt]  = bar_p;
        fill_count_nxt = fill_count_nxt + 1'b1;
      end else begin
        if (phase_nxt == PH_SKIP) begin
          if (contain_f(win_high_nxt[0], win_low_nxt[0],
                        win_high_nxt[1], win_low_nxt[1]) != CT_NONE) begin
            win_high_nxt[0] = win_high_nxt[1];
            win_low_nxt[0]  = win_low_nxt[1];
            win_pos_nxt[0]  = win_pos_nxt[1];
            win_high_nxt[1] = win_high_nxt[2];
            win_low_nxt[1]  = win_low_nxt[2];
            win_pos_nxt[1]  = win_pos_nxt[2];
            win_high_nxt[2] = bar_h;
            win_low_nxt[2]  = bar_l;
            win_pos_nxt[2]  = bar_p;
            step_done = 1'b1;
          end else begin
            phase_nxt = PH_MERGE;
          end
        end

        if (!step_done && phase_nxt == PH_MERGE) begin
          cont_c = contain_f(win_high_nxt[1], win_low_nxt[1],
                             win_high_nxt[2], win_low_nxt[2]);
          if (cont_c != CT_NONE) begin
            step_done = 1'b1;
            trend_d = trend_f(win_high_nxt[0], win_low_nxt[0],
                              win_high_nxt[1], win_low_nxt[1]);
            if (trend_d == TR_FLAT) begin
              halted_nxt = 1'b1;
              res_valid  = 1'b1;
              res_kind   = bmfd_pkg::EV_ERROR;
              res_pos    = bmfd_pkg::BAR_POS_W'(bar_p);
              res_price  = '0;
              res_seq    = peak_counter_nxt;
            end else begin
              if (cont_c == CT_B_IN_A) begin
                // slot 1 holds slot 2; slot 1 kept
                if (trend_d == TR_UP) begin
                  win_low_nxt[1] = win_low_nxt[2];
                end else begin
                  win_high_nxt[1] = win_high_nxt[2];
                end
              end else begin
                // slot 2 holds slot 1; slot 2 kept and moves down
                if (trend_d == TR_UP) begin
                  win_high_nxt[1] = win_high_nxt[2];
                end else begin
                  win_low_nxt[1] = win_low_nxt[2];
                end
                win_pos_nxt[1] = win_pos_nxt[2];
              end
              win_high_nxt[2] = bar_h;
              win_low_nxt[2]  = bar_l;
              win_pos_nxt[2]  = bar_p;
            end
          end else begin
            phase_nxt = PH_DETECT;
          end
        end

        if (!step_done && phase_nxt == PH_DETECT) begin
          cont_c = contain_f(win_high_nxt[2], win_low_nxt[2], bar_h, bar_l);
          if (cont_c != CT_NONE) begin
            trend_d = trend_f(win_high_nxt[1], win_low_nxt[1],
                              win_high_nxt[2], win_low_nxt[2]);
            if (trend_d == TR_FLAT) begin
              halted_nxt = 1'b1;
              res_valid  = 1'b1;
              res_kind   = bmfd_pkg::EV_ERROR;
              res_pos    = bmfd_pkg::BAR_POS_W'(bar_p);
              res_price  = '0;
              res_seq    = peak_counter_nxt;
            end else if (cont_c == CT_B_IN_A) begin
              // newest bar inside slot 2
              if (trend_d == TR_UP) begin
                win_low_nxt[2] = bar_l;
              end else begin
                win_high_nxt[2] = bar_h;
              end
            end else begin
              // slot 2 inside newest bar; merged bar replaces slot 2
              if (trend_d == TR_UP) begin
                win_high_nxt[2] = bar_h;
              end else begin
                win_low_nxt[2] = bar_l;
              end
              win_pos_nxt[2] = bar_p;
            end
          end else begin
            // fractal test on the middle bar
            if (win_high_nxt[0] > win_high_nxt[1] && win_high_nxt[2] > win_high_nxt[1] &&
                win_low_nxt[0]  > win_low_nxt[1]  && win_low_nxt[2]  > win_low_nxt[1]) begin
              res_valid = 1'b1;
              res_kind  = bmfd_pkg::EV_BOTTOM;
              res_price = bmfd_pkg::BAR_PRICE_W'(win_low_nxt[1]);
            end else if (win_high_nxt[0] < win_high_nxt[1] &&
                         win_high_nxt[2] < win_high_nxt[1] &&
                         win_low_nxt[0]  < win_low_nxt[1]  &&
                         win_low_nxt[2]  < win_low_nxt[1]) begin
              res_valid = 1'b1;
              res_kind  = bmfd_pkg::EV_TOP;
              res_price = bmfd_pkg::BAR_PRICE_W'(win_high_nxt[1]);
            end
            if (res_valid) begin
              res_pos          = bmfd_pkg::BAR_POS_W'(win_pos_nxt[1]);
              res_seq          = peak_counter_nxt;
              peak_counter_nxt = peak_counter_nxt + 1'b1;
            end
            win_high_nxt[0] = win_high_nxt[1];
            win_low_nxt[0]  = win_low_nxt[1];
            win_pos_nxt[0]  = win_pos_nxt[1];
            win_high_nxt[1] = win_high_nxt[2];
            win_low_nxt[1]  = win_low_nxt[2];
            win_pos_nxt[1]  = win_pos_nxt[2];
            win_high_nxt[2] = bar_h;
            win_low_nxt[2]  = bar_l;
            win_pos_nxt[2]  = bar_p;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // State and result register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r   <= '0;
      phase_r        <= PH_SKIP;
      halted_r       <= 1'b0;
      peak_counter_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_xfer) begin
        win_high_r     <= win_high_nxt;
        win_low_r      <= win_low_nxt;
        win_pos_r      <= win_pos_nxt;
        fill_count_r   <= fill_count_nxt;
        phase_r        <= phase_nxt;
        halted_r       <= halted_nxt;
        peak_counter_r <= peak_counter_nxt;
        // in_xfer implies the old result is gone or leaves now
        out_valid_r    <= res_valid;
        out_kind_r     <= res_kind;
        out_pos_r      <= res_pos;
        out_price_r    <= res_price;
        out_seq_r      <= res_seq;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_kind_r;
  assign out_peak_pos   = out_pos_r;
  assign out_peak_price = out_price_r;
  assign out_peak_seq   = out_seq_r;

`ifndef SYNTHESIS
  // Window must be full before the phase leaves skip.
  a_phase_needs_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_count_r != bmfd_pkg::FILL_W'(bmfd_pkg::WIN_DEPTH)) |-> (phase_r == PH_SKIP))
    else $error("phase advanced before window filled");

  // Halt is entered only together with an error result.
  a_halt_reports: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(halted_r) |-> (out_valid_r && out_kind_r == bmfd_pkg::EV_ERROR))
    else $error("halt without error result");

  // A pending error result means the unit is halted.
  a_error_halted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == bmfd_pkg::EV_ERROR) |-> halted_r)
    else $error("error result while not halted");

  // A pending peak result carries the sequence number just consumed.
  a_peak_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == bmfd_pkg::EV_BOTTOM || out_kind_r == bmfd_pkg::EV_TOP))
      |-> (peak_counter_r == out_seq_r + 1'b1))
    else $error("peak counter out of step with result");
`endif

endmodule

`default_nettype wire
